FILE: rtl/grst_pkg.sv
`default_nettype none

package grst_pkg;

   // field and datapath widths
   localparam int QW      = 16;             // quaternion and gravity components
   localparam int KW      = 15;             // keep weight, Q0.15
   localparam int OW      = 15;             // Q7.8 outputs
   localparam int QFB     = 14;             // quaternion fraction bits
   localparam int FW      = 24;             // smoother state width
   localparam int FFRAC   = FW - 8;         // smoother fraction bits
   localparam int TW      = QW + 3;         // rounded g*q part
   localparam int RW      = TW + QW + 2;    // sum of four t*q products
   localparam int AW      = 60;             // accumulator and shifted multiplicand
   localparam int MPW     = 24;             // multiplier shift register
   localparam int DIGW    = 4;              // multiplier digit per cycle
   localparam int DCW     = 3;              // digit counter
   localparam int STEP_W  = 5;
   localparam int REQ_W   = 4 * QW;
   localparam int RSP_W   = ((3 * OW + 7) / 8) * 8;
   localparam int D_SHIFT = (2 * QFB + 16 - FFRAC > 62) ? 62 : 2 * QFB + 16 - FFRAC;
   localparam int O_SHIFT = FFRAC - 8;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(29);
   localparam logic [DCW-1:0]    NDIG_Q    = DCW'(4);
   localparam logic [DCW-1:0]    NDIG_C    = DCW'(6);

   // 57.2958 in Q8.16
   localparam logic signed [MPW-1:0] RAD2DEG = MPW'(3754940);

   // rounding constants (half of the dropped weight)
   localparam logic [AW-1:0] T_HALF = AW'(64'd1 << (QFB - 1));
   localparam logic [AW-1:0] D_HALF = AW'(64'd1 << (D_SHIFT - 1));
   localparam logic [AW-1:0] F_HALF = AW'(64'd1 << (KW - 1));
   localparam logic [FW:0]   O_HALF = (FW + 1)'(64'd1 << (O_SHIFT - 1));

   localparam logic signed [AW-1:0] FILT_HI = AW'((64'sd1 <<< (FW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] FILT_LO = AW'(-(64'sd1 <<< (FW - 1)));
   localparam logic signed [FW-O_SHIFT:0] OUT_HI = (FW - O_SHIFT + 1)'(16383);
   localparam logic signed [FW-O_SHIFT:0] OUT_LO = (FW - O_SHIFT + 1)'(-16384);

   // operation kinds of the sequencer program
   localparam logic [1:0] OP_T = 2'd0;   // g*q product term
   localparam logic [1:0] OP_R = 2'd1;   // conj(q)*t product term
   localparam logic [1:0] OP_D = 2'd2;   // radians to degrees
   localparam logic [1:0] OP_S = 2'd3;   // smoother update

   // component selectors
   localparam logic [1:0] C_W = 2'd0;
   localparam logic [1:0] C_X = 2'd1;
   localparam logic [1:0] C_Y = 2'd2;
   localparam logic [1:0] C_Z = 2'd3;
   localparam logic [1:0] G_X = 2'd0;
   localparam logic [1:0] G_Y = 2'd1;
   localparam logic [1:0] G_Z = 2'd2;

   typedef logic signed [QW-1:0] comp_type;
   typedef logic signed [FW-1:0] filt_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] mc_sel;
      logic [1:0] mp_sel;
      logic       neg;
      logic       first;
      logic       last;
      logic [1:0] dst;
   } op_type;

   function automatic op_type mk_op(input logic [1:0] kind, input logic [1:0] mc_sel,
                                    input logic [1:0] mp_sel, input logic neg,
                                    input logic first, input logic last,
                                    input logic [1:0] dst);
      op_type o;
      o.kind   = kind;
      o.mc_sel = mc_sel;
      o.mp_sel = mp_sel;
      o.neg    = neg;
      o.first  = first;
      o.last   = last;
      o.dst    = dst;
      return o;
   endfunction

   // sequencer program: t = g*q, r = conj(q)*t, then degrees and smoothing per axis
   function automatic op_type op_of(input logic [STEP_W-1:0] step);
      op_type o;
      unique case (step)
         5'd0:    o = mk_op(OP_T, G_X, C_X, 1'b1, 1'b1, 1'b0, C_W);
         5'd1:    o = mk_op(OP_T, G_Y, C_Y, 1'b1, 1'b0, 1'b0, C_W);
         5'd2:    o = mk_op(OP_T, G_Z, C_Z, 1'b1, 1'b0, 1'b1, C_W);
         5'd3:    o = mk_op(OP_T, G_X, C_W, 1'b0, 1'b1, 1'b0, C_X);
         5'd4:    o = mk_op(OP_T, G_Y, C_Z, 1'b0, 1'b0, 1'b0, C_X);
         5'd5:    o = mk_op(OP_T, G_Z, C_Y, 1'b1, 1'b0, 1'b1, C_X);
         5'd6:    o = mk_op(OP_T, G_X, C_Z, 1'b1, 1'b1, 1'b0, C_Y);
         5'd7:    o = mk_op(OP_T, G_Y, C_W, 1'b0, 1'b0, 1'b0, C_Y);
         5'd8:    o = mk_op(OP_T, G_Z, C_X, 1'b0, 1'b0, 1'b1, C_Y);
         5'd9:    o = mk_op(OP_T, G_X, C_Y, 1'b0, 1'b1, 1'b0, C_Z);
         5'd10:   o = mk_op(OP_T, G_Y, C_X, 1'b1, 1'b0, 1'b0, C_Z);
         5'd11:   o = mk_op(OP_T, G_Z, C_W, 1'b0, 1'b0, 1'b1, C_Z);
         5'd12:   o = mk_op(OP_R, C_X, C_W, 1'b0, 1'b1, 1'b0, 2'd0);
         5'd13:   o = mk_op(OP_R, C_W, C_X, 1'b1, 1'b0, 1'b0, 2'd0);
         5'd14:   o = mk_op(OP_R, C_Z, C_Y, 1'b1, 1'b0, 1'b0, 2'd0);
         5'd15:   o = mk_op(OP_R, C_Y, C_Z, 1'b0, 1'b0, 1'b1, 2'd0);
         5'd16:   o = mk_op(OP_R, C_Y, C_W, 1'b0, 1'b1, 1'b0, 2'd1);
         5'd17:   o = mk_op(OP_R, C_Z, C_X, 1'b0, 1'b0, 1'b0, 2'd1);
         5'd18:   o = mk_op(OP_R, C_W, C_Y, 1'b1, 1'b0, 1'b0, 2'd1);
         5'd19:   o = mk_op(OP_R, C_X, C_Z, 1'b1, 1'b0, 1'b1, 2'd1);
         5'd20:   o = mk_op(OP_R, C_Z, C_W, 1'b0, 1'b1, 1'b0, 2'd2);
         5'd21:   o = mk_op(OP_R, C_Y, C_X, 1'b1, 1'b0, 1'b0, 2'd2);
         5'd22:   o = mk_op(OP_R, C_X, C_Y, 1'b0, 1'b0, 1'b0, 2'd2);
         5'd23:   o = mk_op(OP_R, C_W, C_Z, 1'b1, 1'b0, 1'b1, 2'd2);
         5'd24:   o = mk_op(OP_D, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd0);
         5'd25:   o = mk_op(OP_S, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd0);
         5'd26:   o = mk_op(OP_D, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd1);
         5'd27:   o = mk_op(OP_S, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd1);
         5'd28:   o = mk_op(OP_D, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd2);
         5'd29:   o = mk_op(OP_S, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd2);
         default: o = mk_op(OP_S, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd2);
      endcase
      return o;
   endfunction

   // clamp to the smoother range
   function automatic filt_type sat_filt(input logic signed [AW-1:0] v);
      priority if (v > FILT_HI) begin
         return FILT_HI[FW-1:0];
      end else if (v < FILT_LO) begin
         return FILT_LO[FW-1:0];
      end else begin
         return v[FW-1:0];
      end
   endfunction

   // clamp to the Q7.8 output range
   function automatic logic [OW-1:0] sat_out(input logic signed [FW-O_SHIFT:0] v);
      priority if (v > OUT_HI) begin
         return OUT_HI[OW-1:0];
      end else if (v < OUT_LO) begin
         return OUT_LO[OW-1:0];
      end else begin
         return v[OW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gravity_rotate_smooth_tilt.sv
`default_nettype none

// Channel  Ports                      Payload (lowest bits first)
// req      req_tvalid/tready/tdata    quat_w, quat_x, quat_y, quat_z (16 b each)
// rsp      rsp_tvalid/tready/tdata    roll_deg, pitch_deg, yaw_deg (15 b each), 3 b zero
// csr      csr_we/index/wdata         0 gravity_x, 1 gravity_y, 2 gravity_z, 3 keep_weight
//
// A transaction holds the block from accept until its result is issued: 30 products run
// through one shared multiply-accumulate that consumes a 4-bit multiplier digit per
// cycle, with a load state before each product and a store state after each result group.
// Reset is synchronous; it restores the register defaults and clears the smoothers.
// A result waiting on rsp does not block req; a new result waits only if the
// previous one is still untaken when the next transaction finishes.
module gravity_rotate_smooth_tilt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [grst_pkg::REQ_W-1:0]   req_tdata,    // quat_w, quat_x, quat_y, quat_z
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [grst_pkg::RSP_W-1:0]   rsp_tdata,    // roll_deg, pitch_deg, yaw_deg, pad
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [grst_pkg::QW-1:0]      csr_wdata
);
   import grst_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_STORE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [1:0] CSR_GX   = 2'd0;
   localparam logic [1:0] CSR_GY   = 2'd1;
   localparam logic [1:0] CSR_GZ   = 2'd2;
   localparam logic [1:0] CSR_KEEP = 2'd3;

   logic [2:0]              state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [DCW-1:0]          dig_ff, dig_in;
   logic [DCW-1:0]          ndig_ff, ndig_in;
   logic signed [AW-1:0]    mc_ff, mc_in;
   logic signed [MPW-1:0]   mp_ff, mp_in;
   logic signed [AW-1:0]    acc_ff, acc_in;
   comp_type                q_ff [0:3];
   comp_type                q_in [0:3];
   logic signed [TW-1:0]    t_ff [0:3];
   logic signed [TW-1:0]    t_in [0:3];
   logic signed [RW-1:0]    r_ff [0:2];
   logic signed [RW-1:0]    r_in [0:2];
   filt_type                s_ff, s_in;
   filt_type                filt_ff [0:2];
   filt_type                filt_in [0:2];
   comp_type                g_ff [0:2];
   comp_type                g_in [0:2];
   logic [KW-1:0]           keep_ff, keep_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   op_type                  op;
   logic                    dig_last;
   logic signed [DIGW:0]    dig_s;
   logic signed [AW+DIGW:0] prod_full;
   logic signed [AW-1:0]    partial;
   logic signed [AW-1:0]    acc_sum;
   comp_type                g_sel;
   comp_type                q_sel;
   logic signed [TW-1:0]    t_sel;
   logic signed [RW-1:0]    r_sel;
   filt_type                f_sel;
   logic signed [FW:0]      f_diff;
   logic signed [AW-1:0]    s_init;
   logic signed [AW-1:0]    t_sum;
   logic signed [AW-1:0]    d_sum;
   logic signed [AW-1:0]    f_sum;
   logic signed [TW-1:0]    t_rnd;
   filt_type                s_val;
   filt_type                f_val;
   logic signed [FW:0]      o_sum [0:2];
   logic [OW-1:0]           o_val [0:2];

   assign op         = op_of(step_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // select operands for the current product
   always_comb begin
      g_sel = g_ff[0];
      q_sel = q_ff[0];
      t_sel = t_ff[0];
      r_sel = r_ff[0];
      f_sel = filt_ff[0];
      for (int i = 0; i < 3; i++) begin
         if (op.mc_sel == 2'(i)) g_sel = g_ff[i];
         if (op.dst == 2'(i)) begin
            r_sel = r_ff[i];
            f_sel = filt_ff[i];
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (op.mp_sel == 2'(i)) q_sel = q_ff[i];
         if (op.mc_sel == 2'(i)) t_sel = t_ff[i];
      end
   end

   assign f_diff = (FW + 1)'(f_sel) - (FW + 1)'(s_ff);
   assign s_init = AW'(s_ff) <<< KW;

   // one digit of the shared multiplier; the top digit carries the sign
   assign dig_last  = (dig_ff == ndig_ff - DCW'(1));
   assign dig_s     = dig_last ? $signed({mp_ff[DIGW-1], mp_ff[DIGW-1:0]})
                               : $signed({1'b0, mp_ff[DIGW-1:0]});
   assign prod_full = mc_ff * dig_s;
   assign partial   = prod_full[AW-1:0];
   assign acc_sum   = op.neg ? acc_ff - partial : acc_ff + partial;

   // round and clamp accumulated groups
   assign t_sum = acc_ff + T_HALF;
   assign d_sum = acc_ff + D_HALF;
   assign f_sum = acc_ff + F_HALF;
   assign t_rnd = t_sum[QFB+TW-1:QFB];
   assign s_val = sat_filt(d_sum >>> D_SHIFT);
   assign f_val = sat_filt(f_sum >>> KW);

   // round the smoothed values to Q7.8
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_sum[i] = (FW + 1)'(filt_ff[i]) + $signed(O_HALF);
         o_val[i] = sat_out(o_sum[i][FW:O_SHIFT]);
      end
   end

   // configuration writes
   always_comb begin
      g_in    = g_ff;
      keep_in = keep_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GX:   g_in[0] = csr_wdata;
            CSR_GY:   g_in[1] = csr_wdata;
            CSR_GZ:   g_in[2] = csr_wdata;
            CSR_KEEP: keep_in = csr_wdata[KW-1:0];
            default:  keep_in = keep_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dig_in       = dig_ff;
      ndig_in      = ndig_ff;
      mc_in        = mc_ff;
      mp_in        = mp_ff;
      acc_in       = acc_ff;
      q_in         = q_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      s_in         = s_ff;
      filt_in      = filt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop a taken result
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 4; i++) q_in[i] = req_tdata[i*QW +: QW];
               step_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dig_in = '0;
            unique case (op.kind)
               OP_T: begin
                  mc_in   = AW'(g_sel);
                  mp_in   = MPW'(q_sel);
                  ndig_in = NDIG_Q;
               end
               OP_R: begin
                  mc_in   = AW'(t_sel);
                  mp_in   = MPW'(q_sel);
                  ndig_in = NDIG_Q;
               end
               OP_D: begin
                  mc_in   = AW'(r_sel);
                  mp_in   = RAD2DEG;
                  ndig_in = NDIG_C;
               end
               OP_S: begin
                  mc_in   = AW'(f_diff);
                  mp_in   = $signed(MPW'(keep_ff));
                  ndig_in = NDIG_Q;
               end
               default: ndig_in = NDIG_Q;
            endcase
            if (op.first) acc_in = (op.kind == OP_S) ? s_init : '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_sum;
            mc_in  = mc_ff <<< DIGW;
            mp_in  = mp_ff >>> DIGW;
            dig_in = dig_ff + DCW'(1);
            if (dig_last) begin
               if (op.last) begin
                  state_in = ST_STORE;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_STORE: begin
            unique case (op.kind)
               OP_T: begin
                  for (int i = 0; i < 4; i++) if (op.dst == 2'(i)) t_in[i] = t_rnd;
               end
               OP_R: begin
                  for (int i = 0; i < 3; i++) if (op.dst == 2'(i)) r_in[i] = acc_ff[RW-1:0];
               end
               OP_D: s_in = s_val;
               OP_S: begin
                  for (int i = 0; i < 3; i++) if (op.dst == 2'(i)) filt_in[i] = f_val;
               end
               default: s_in = s_ff;
            endcase
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({o_val[2], o_val[1], o_val[0]});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control, configuration and smoother state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         g_ff[0]      <= '0;
         g_ff[1]      <= '0;
         g_ff[2]      <= comp_type'(16384);
         keep_ff      <= KW'(26214);
         for (int i = 0; i < 3; i++) filt_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
         g_ff         <= g_in;
         keep_ff      <= keep_in;
         filt_ff      <= filt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ndig_ff     <= ndig_in;
      mc_ff       <= mc_in;
      mp_ff       <= mp_in;
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   // accepted transaction starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LOAD && step_ff == '0))
      else $error("program did not start after accept");

   // digit counter stays below the digit count of the current product
   a_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (dig_ff < ndig_ff))
      else $error("digit counter overran");

   // step counter never passes the end of the program
   a_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= LAST_STEP))
      else $error("step counter overran");

   // a new result is issued only from the finishing state
   a_issue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result issued outside finish");

endmodule

`default_nettype wire
